/* rtl/assert_macros.svh */
// Assertion shorthands for the checker. Both expect clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define CHK_NOW(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check a condition in the cycle after a trigger.
`define CHK_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

/* rtl/bbp_pkg.sv */
`timescale 1ns / 1ps

package bbp_pkg;

	// Default field formats
	localparam int COORD_BITS_DEF      = 16;
	localparam int PARAM_FRAC_BITS_DEF = 16;

	// Grid shape: 4 rows (u) by 4 columns (v), three coordinates per point
	localparam int GRID_PTS = 16;
	localparam int PT_BITS  = 4;
	localparam int NAXES    = 3;

	// Width of one weight digit fed to the digit multiplier
	localparam int DIGIT_BITS = 16;

	// Cycles from a parameter register to settled weights
	localparam int WGT_LAT = 3;

	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_EVAL = 1'b1
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WGT,
		ST_RUN,
		ST_DRAIN,
		ST_ROUND
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load_pt;
		logic start_eval;
		logic issue;
		logic load_out;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic pipe_busy;
		logic out_full;
	} sts_t;

endpackage

/* rtl/bbp_ifs.sv */
`timescale 1ns / 1ps

// Input channel: load or evaluate items
interface bbp_in_if #(
	parameter int COORD_BITS      = bbp_pkg::COORD_BITS_DEF,
	parameter int PARAM_FRAC_BITS = bbp_pkg::PARAM_FRAC_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic                          action;
	logic [1:0]                    point_row;
	logic [1:0]                    point_col;
	logic signed [COORD_BITS-1:0]  coord_x;
	logic signed [COORD_BITS-1:0]  coord_y;
	logic signed [COORD_BITS-1:0]  coord_z;
	logic [PARAM_FRAC_BITS:0]      param_u;
	logic [PARAM_FRAC_BITS:0]      param_v;

	modport source (
		output valid, action, point_row, point_col, coord_x, coord_y, coord_z,
		       param_u, param_v,
		input  ready
	);
	modport sink (
		input  valid, action, point_row, point_col, coord_x, coord_y, coord_z,
		       param_u, param_v,
		output ready
	);
endinterface

// Output channel: evaluated surface points
interface bbp_out_if #(
	parameter int COORD_BITS = bbp_pkg::COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;
	logic signed [COORD_BITS-1:0] point_z;

	modport source (
		output valid, point_x, point_y, point_z,
		input  ready
	);
	modport sink (
		input  valid, point_x, point_y, point_z,
		output ready
	);
endinterface

/* rtl/bbp_ctrl.sv */
`timescale 1ns / 1ps

module bbp_ctrl #(
	parameter int PARAM_FRAC_BITS = bbp_pkg::PARAM_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	input  logic                              req_action,
	output logic                              req_ready,
	input  bbp_pkg::sts_t                     sts,
	output bbp_pkg::cmd_t                     cmd,
	output logic [bbp_pkg::PT_BITS-1:0]       pt_idx,
	output logic [$clog2((3*PARAM_FRAC_BITS+bbp_pkg::DIGIT_BITS)
	                     / bbp_pkg::DIGIT_BITS)-1:0] dig_i,
	output logic [$clog2((3*PARAM_FRAC_BITS+bbp_pkg::DIGIT_BITS)
	                     / bbp_pkg::DIGIT_BITS)-1:0] dig_j
);
	import bbp_pkg::*;

	localparam int WB  = 3 * PARAM_FRAC_BITS + 1;
	localparam int ND  = (WB + DIGIT_BITS - 1) / DIGIT_BITS;
	localparam int DIW = $clog2(ND);
	localparam int WCW = $clog2(WGT_LAT);

	state_t           state_q;
	state_t           state_d;
	logic [WCW-1:0]   wcnt_q;
	logic [PT_BITS-1:0] pt_q;
	logic [DIW-1:0]   di_q;
	logic [DIW-1:0]   dj_q;
	logic             dj_last;
	logic             di_last;
	logic             run_last;
	logic             accept;

	assign dj_last  = (dj_q == DIW'(ND - 1));
	assign di_last  = (di_q == DIW'(ND - 1));
	assign run_last = dj_last && di_last && (pt_q == PT_BITS'(GRID_PTS - 1));
	assign accept   = req_valid && req_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid && (req_action == ACT_EVAL)) state_d = ST_WGT;
			end
			ST_WGT: begin
				if (wcnt_q == WCW'(WGT_LAT - 1)) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (run_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy) state_d = ST_ROUND;
			end
			ST_ROUND: begin
				if (!sts.out_full) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		req_ready      = 1'b0;
		cmd.load_pt    = 1'b0;
		cmd.start_eval = 1'b0;
		cmd.issue      = 1'b0;
		cmd.load_out   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready      = 1'b1;
				cmd.load_pt    = req_valid && (req_action == ACT_LOAD);
				cmd.start_eval = req_valid && (req_action == ACT_EVAL);
			end
			ST_RUN: begin
				cmd.issue = 1'b1;
			end
			ST_ROUND: begin
				cmd.load_out = !sts.out_full;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Count weight settling cycles
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcnt_q <= '0;
		end else if (state_q == ST_WGT) begin
			wcnt_q <= wcnt_q + WCW'(1);
		end else begin
			wcnt_q <= '0;
		end
	end

	// Walk grid points and weight digit pairs, column digit fastest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_q <= '0;
			di_q <= '0;
			dj_q <= '0;
		end else if (state_q == ST_RUN) begin
			dj_q <= dj_last ? '0 : dj_q + DIW'(1);
			if (dj_last) begin
				di_q <= di_last ? '0 : di_q + DIW'(1);
				if (di_last) pt_q <= pt_q + PT_BITS'(1);
			end
		end else if (accept) begin
			pt_q <= '0;
			di_q <= '0;
			dj_q <= '0;
		end
	end

	assign pt_idx = pt_q;
	assign dig_i  = di_q;
	assign dig_j  = dj_q;

endmodule

/* rtl/bbp_wgt.sv */
`timescale 1ns / 1ps

// Bernstein weights of one parameter, exact, three register stages
module bbp_wgt #(
	parameter int PARAM_FRAC_BITS = bbp_pkg::PARAM_FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic [PARAM_FRAC_BITS:0]             t,
	output logic [3:0][3*PARAM_FRAC_BITS:0]      w
);
	localparam int PWD = PARAM_FRAC_BITS + 1;
	localparam int SQW = 2 * PWD;
	localparam int WB  = 3 * PARAM_FRAC_BITS + 1;
	localparam int WW  = 3 * PWD + 2;

	logic [PWD-1:0]        s;
	logic [PWD-1:0]        t_s1;
	logic [PWD-1:0]        s_s1;
	logic [SQW-1:0]        tt_s1;
	logic [SQW-1:0]        ss_s1;
	logic [3:0][SQW-1:0]   sq_sel;
	logic [3:0][PWD-1:0]   f_sel;
	logic [3:0][SQW-1:0]   phi_s2;
	logic [3:0][SQW-1:0]   plo_s2;
	logic [3:0][WW-1:0]    full;
	logic [3:0][WW-1:0]    tri3;
	logic [3:0][WB-1:0]    w_s3;

	assign s = (PWD'(1) << PARAM_FRAC_BITS) - t;

	// Squares of t and 1-t
	always_ff @(posedge clk) begin
		t_s1  <= t;
		s_s1  <= s;
		tt_s1 <= SQW'(t) * SQW'(t);
		ss_s1 <= SQW'(s) * SQW'(s);
	end

	// Pick square and third factor for each weight
	always_comb begin
		sq_sel[0] = ss_s1;  f_sel[0] = s_s1;
		sq_sel[1] = ss_s1;  f_sel[1] = t_s1;
		sq_sel[2] = tt_s1;  f_sel[2] = s_s1;
		sq_sel[3] = tt_s1;  f_sel[3] = t_s1;
	end

	// Multiply each half of the square by the third factor
	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			phi_s2[k] <= SQW'(sq_sel[k][SQW-1:PWD]) * SQW'(f_sel[k]);
			plo_s2[k] <= SQW'(sq_sel[k][PWD-1:0]) * SQW'(f_sel[k]);
		end
	end

	// Join halves, triple the inner two weights
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			full[k] = (WW'(phi_s2[k]) << PWD) + WW'(plo_s2[k]);
			tri3[k] = (full[k] << 1) + full[k];
		end
	end

	always_ff @(posedge clk) begin
		w_s3[0] <= WB'(full[0]);
		w_s3[1] <= WB'(tri3[1]);
		w_s3[2] <= WB'(tri3[2]);
		w_s3[3] <= WB'(full[3]);
	end

	assign w = w_s3;

endmodule

/* rtl/bbp_dp.sv */
`timescale 1ns / 1ps

module bbp_dp #(
	parameter int COORD_BITS      = bbp_pkg::COORD_BITS_DEF,
	parameter int PARAM_FRAC_BITS = bbp_pkg::PARAM_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bbp_pkg::cmd_t                     cmd,
	output bbp_pkg::sts_t                     sts,
	input  logic [bbp_pkg::PT_BITS-1:0]       pt_idx,
	input  logic [$clog2((3*PARAM_FRAC_BITS+bbp_pkg::DIGIT_BITS)
	                     / bbp_pkg::DIGIT_BITS)-1:0] dig_i,
	input  logic [$clog2((3*PARAM_FRAC_BITS+bbp_pkg::DIGIT_BITS)
	                     / bbp_pkg::DIGIT_BITS)-1:0] dig_j,
	input  logic [1:0]                        point_row,
	input  logic [1:0]                        point_col,
	input  logic signed [COORD_BITS-1:0]      coord_x,
	input  logic signed [COORD_BITS-1:0]      coord_y,
	input  logic signed [COORD_BITS-1:0]      coord_z,
	input  logic [PARAM_FRAC_BITS:0]          param_u,
	input  logic [PARAM_FRAC_BITS:0]          param_v,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [COORD_BITS-1:0]      point_x,
	output logic signed [COORD_BITS-1:0]      point_y,
	output logic signed [COORD_BITS-1:0]      point_z
);
	import bbp_pkg::*;

	localparam int PWD = PARAM_FRAC_BITS + 1;
	localparam int WB  = 3 * PARAM_FRAC_BITS + 1;
	localparam int D   = DIGIT_BITS;
	localparam int ND  = (WB + D - 1) / D;
	localparam int DIW = $clog2(ND);
	localparam int SHW = $clog2(2 * ND - 1);
	localparam int PW  = 2 * D;
	localparam int TW  = PW + 1 + COORD_BITS;
	localparam int FB  = 6 * PARAM_FRAC_BITS;
	localparam int AW  = FB + COORD_BITS;

	logic [2:0][COORD_BITS-1:0]  grid_q [GRID_PTS];
	logic [GRID_PTS-1:0]         gvld_q;
	logic [PT_BITS-1:0]          wr_idx;
	logic [PWD-1:0]              one_t;
	logic [PWD-1:0]              tu_q;
	logic [PWD-1:0]              tv_q;
	logic [3:0][WB-1:0]          wu;
	logic [3:0][WB-1:0]          wv;
	logic [ND*D-1:0]             wu_pad;
	logic [ND*D-1:0]             wv_pad;
	logic [D-1:0]                dig_a;
	logic [D-1:0]                dig_b;
	logic [PW-1:0]               prod_s1;
	logic [2:0][COORD_BITS-1:0]  crd_s1;
	logic [SHW-1:0]              sh_s1;
	logic                        vld_s1;
	logic signed [TW-1:0]        term_s2 [NAXES];
	logic [SHW-1:0]              sh_s2;
	logic                        vld_s2;
	logic [AW-1:0]               tsh [NAXES];
	logic [AW-1:0]               acc_q [NAXES];
	logic [AW-1:0]               rnd [NAXES];
	logic [2:0][COORD_BITS-1:0]  res_q;
	logic                        out_vld_q;

	assign wr_idx = {point_row, point_col};
	assign one_t  = PWD'(1) << PARAM_FRAC_BITS;

	// Write one control point per load beat
	always_ff @(posedge clk) begin
		if (cmd.load_pt) grid_q[wr_idx] <= {coord_z, coord_y, coord_x};
	end

	// Mark written points; unwritten ones read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gvld_q <= '0;
		end else if (cmd.load_pt) begin
			gvld_q[wr_idx] <= 1'b1;
		end
	end

	// Hold parameters, saturated to one
	always_ff @(posedge clk) begin
		if (cmd.start_eval) begin
			tu_q <= (param_u > one_t) ? one_t : param_u;
			tv_q <= (param_v > one_t) ? one_t : param_v;
		end
	end

	bbp_wgt #(.PARAM_FRAC_BITS(PARAM_FRAC_BITS)) u_wgt_u (
		.clk (clk),
		.t   (tu_q),
		.w   (wu)
	);

	bbp_wgt #(.PARAM_FRAC_BITS(PARAM_FRAC_BITS)) u_wgt_v (
		.clk (clk),
		.t   (tv_q),
		.w   (wv)
	);

	// Select the weight digits for this grid point
	assign wu_pad = (ND*D)'(wu[pt_idx[3:2]]);
	assign wv_pad = (ND*D)'(wv[pt_idx[1:0]]);
	assign dig_a  = wu_pad[dig_i*D +: D];
	assign dig_b  = wv_pad[dig_j*D +: D];

	// Stage 1: digit product, fetch control point
	always_ff @(posedge clk) begin
		prod_s1 <= PW'(dig_a) * PW'(dig_b);
		crd_s1  <= gvld_q[pt_idx] ? grid_q[pt_idx] : '0;
		sh_s1   <= SHW'(dig_i) + SHW'(dig_j);
	end

	// Stage 2: scale each coordinate
	always_ff @(posedge clk) begin
		for (int k = 0; k < NAXES; k++) begin
			term_s2[k] <= $signed({1'b0, prod_s1}) * $signed(crd_s1[k]);
		end
		sh_s2 <= sh_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			vld_s2 <= vld_s1;
		end
	end

	// Stage 3: align by digit position and accumulate
	always_comb begin
		for (int k = 0; k < NAXES; k++) begin
			tsh[k] = AW'(term_s2[k]) << (D * sh_s2);
			rnd[k] = acc_q[k] + (AW'(1) << (FB - 1));
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NAXES; k++) begin
			if (cmd.start_eval) begin
				acc_q[k] <= '0;
			end else if (vld_s2) begin
				acc_q[k] <= acc_q[k] + tsh[k];
			end
		end
	end

	// Round half up and hold the result until taken
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			for (int k = 0; k < NAXES; k++) begin
				res_q[k] <= rnd[k][AW-1:FB];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign sts.pipe_busy = vld_s1 || vld_s2;
	assign sts.out_full  = out_vld_q && !out_ready;

	assign out_valid = out_vld_q;
	assign point_x   = res_q[0];
	assign point_y   = res_q[1];
	assign point_z   = res_q[2];

endmodule

/* rtl/bicubic_bezier_patch_eval.sv */
`timescale 1ns / 1ps

// Bicubic Bezier patch evaluator. A load beat writes one of the 16 control
// points (cleared to zero at reset) and returns nothing. An evaluate beat
// returns one surface point, sum of Bu_r(u)*Bv_c(v)*P[r][c], formed exactly
// and rounded once to nearest, ties up. Evaluation is done by one digit
// multiply-accumulate chain that handles one pair of 16-bit weight digits for
// one control point per cycle: with ND = ceil((3*PARAM_FRAC_BITS+1) / 16)
// digits per weight, an evaluate beat steps through 16*ND*ND digit pairs
// after its weights settle, then drains the pipeline and rounds into the
// output register. Input ready is high only while no evaluation is in
// progress; the result sits in an output register, so new beats are taken
// while it waits to be read.
module bicubic_bezier_patch_eval #(
	parameter int COORD_BITS      = bbp_pkg::COORD_BITS_DEF,
	parameter int PARAM_FRAC_BITS = bbp_pkg::PARAM_FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	bbp_in_if.sink    req,
	bbp_out_if.source rsp
);
	import bbp_pkg::*;

	localparam int WB  = 3 * PARAM_FRAC_BITS + 1;
	localparam int ND  = (WB + DIGIT_BITS - 1) / DIGIT_BITS;
	localparam int DIW = $clog2(ND);

	cmd_t               cmd;
	sts_t               sts;
	logic [PT_BITS-1:0] pt_idx;
	logic [DIW-1:0]     dig_i;
	logic [DIW-1:0]     dig_j;

	bbp_ctrl #(.PARAM_FRAC_BITS(PARAM_FRAC_BITS)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_action (req.action),
		.req_ready  (req.ready),
		.sts        (sts),
		.cmd        (cmd),
		.pt_idx     (pt_idx),
		.dig_i      (dig_i),
		.dig_j      (dig_j)
	);

	bbp_dp #(
		.COORD_BITS      (COORD_BITS),
		.PARAM_FRAC_BITS (PARAM_FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.pt_idx    (pt_idx),
		.dig_i     (dig_i),
		.dig_j     (dig_j),
		.point_row (req.point_row),
		.point_col (req.point_col),
		.coord_x   (req.coord_x),
		.coord_y   (req.coord_y),
		.coord_z   (req.coord_z),
		.param_u   (req.param_u),
		.param_v   (req.param_v),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.point_x   (rsp.point_x),
		.point_y   (rsp.point_y),
		.point_z   (rsp.point_z)
	);

endmodule

/* rtl/bbp_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bbp_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic req_action,
	input logic rsp_valid,
	input logic rsp_ready
);
	import bbp_pkg::*;

	logic       eval_beat;
	logic       load_beat;
	logic       rsp_beat;
	logic [1:0] pend_q;

	assign eval_beat = req_valid && req_ready && (req_action == ACT_EVAL);
	assign load_beat = req_valid && req_ready && (req_action == ACT_LOAD);
	assign rsp_beat  = rsp_valid && rsp_ready;

	// Track evaluate beats not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(eval_beat) - 2'(rsp_beat);
		end
	end

	`CHK_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped before taken")
	`CHK_NEXT(a_eval_busy, eval_beat, !req_ready, "input taken during evaluation")
	`CHK_NEXT(a_load_free, load_beat, req_ready, "load beat stalled the input")
	`CHK_NOW(a_rsp_owed, !rsp_valid || (pend_q != 2'd0), "result without evaluate beat")
	`CHK_NOW(a_pend_max, pend_q != 2'd3, "too many evaluations outstanding")

endmodule

bind bicubic_bezier_patch_eval bbp_checker u_bbp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.req_action (req.action),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready)
);

/* verif/bicubic_bezier_patch_eval_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the patch evaluator, keeps its own copy of the
// control grid and checks every surface point against an exact prediction.
module bicubic_bezier_patch_eval_checker (
	input  logic clk,
	input  logic arst_n,
	bbp_in_if    req,
	bbp_out_if   rsp,
	output int   err_count,
	output int   pending
);
	import bbp_pkg::*;

	localparam int CB    = COORD_BITS_DEF;
	localparam int PF    = PARAM_FRAC_BITS_DEF;
	localparam int SHIFT = 6 * PF;

	typedef logic signed [127:0] acc_t;
	typedef logic [3:0][63:0] wgt4_t;

	typedef struct packed {
		logic signed [CB-1:0] x;
		logic signed [CB-1:0] y;
		logic signed [CB-1:0] z;
	} surf_pt_t;

	localparam logic [63:0] PARAM_ONE = 64'd1 << PF;
	localparam acc_t ROUND_HALF = acc_t'(1) << (SHIFT - 1);

	// Control points by {row, col}, one coordinate per axis
	logic signed [CB-1:0] grid_pts [GRID_PTS][NAXES];
	surf_pt_t expected_pts [$];
	int mismatches;

	// Bernstein weights of one parameter, exact in Q1.(3*PF)
	function automatic wgt4_t basis_weights(input logic [PF:0] raw);
		logic [63:0] t;
		logic [63:0] s;
		wgt4_t w;
		t = 64'(raw);
		if (t > PARAM_ONE)
			t = PARAM_ONE;
		s = PARAM_ONE - t;
		w[0] = s * s * s;
		w[1] = 64'd3 * t * s * s;
		w[2] = 64'd3 * t * t * s;
		w[3] = t * t * t;
		return w;
	endfunction

	// Exact weighted sum over the grid, rounded once to nearest, ties up
	function automatic surf_pt_t patch_point(input logic [PF:0] u, input logic [PF:0] v);
		wgt4_t wu;
		wgt4_t wv;
		acc_t sum [NAXES];
		acc_t wuv;
		logic [CB-1:0] rnd [NAXES];
		surf_pt_t p;
		int r;
		int c;
		int a;
		wu = basis_weights(u);
		wv = basis_weights(v);
		for (a = 0; a < NAXES; a++)
			sum[a] = '0;
		for (r = 0; r < 4; r++) begin
			for (c = 0; c < 4; c++) begin
				wuv = $signed({64'd0, wu[r]}) * $signed({64'd0, wv[c]});
				for (a = 0; a < NAXES; a++)
					sum[a] = sum[a] + wuv * acc_t'(grid_pts[r * 4 + c][a]);
			end
		end
		for (a = 0; a < NAXES; a++) begin
			sum[a] = sum[a] + ROUND_HALF;
			rnd[a] = sum[a][SHIFT +: CB];
		end
		p.x = rnd[0];
		p.y = rnd[1];
		p.z = rnd[2];
		return p;
	endfunction

	function automatic void report(input string axis, input logic [CB-1:0] want,
			input logic [CB-1:0] got);
		mismatches++;
		$display("%0t: %s expected %0d got %0d", $time, axis, $signed(want),
			$signed(got));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		surf_pt_t want;
		int idx;
		int a;
		if (!arst_n) begin
			for (idx = 0; idx < GRID_PTS; idx++)
				for (a = 0; a < NAXES; a++)
					grid_pts[idx][a] = '0;
			expected_pts.delete();
			mismatches = 0;
			err_count <= 0;
			pending <= 0;
		end else begin
			// Compare an output beat with the oldest prediction first
			if (rsp.valid && rsp.ready) begin
				if (expected_pts.size() == 0) begin
					mismatches++;
					$display("%0t: surface point expected none got (%0d, %0d, %0d)",
						$time, rsp.point_x, rsp.point_y, rsp.point_z);
				end else begin
					want = expected_pts.pop_front();
					if (rsp.point_x !== want.x)
						report("point_x", want.x, rsp.point_x);
					if (rsp.point_y !== want.y)
						report("point_y", want.y, rsp.point_y);
					if (rsp.point_z !== want.z)
						report("point_z", want.z, rsp.point_z);
				end
			end
			// Predict an evaluate beat, or store a loaded control point
			if (req.valid && req.ready) begin
				if (req.action == ACT_EVAL) begin
					expected_pts.push_back(patch_point(req.param_u, req.param_v));
				end else begin
					idx = int'({req.point_row, req.point_col});
					grid_pts[idx][0] = req.coord_x;
					grid_pts[idx][1] = req.coord_y;
					grid_pts[idx][2] = req.coord_z;
				end
			end
			err_count <= mismatches;
			pending <= expected_pts.size();
		end
	end

endmodule

/* verif/bicubic_bezier_patch_eval_test.sv */
`timescale 1ns / 1ps

module bicubic_bezier_patch_eval_test;
	import bbp_pkg::*;

	localparam int CB          = COORD_BITS_DEF;
	localparam int PF          = PARAM_FRAC_BITS_DEF;
	localparam int RAND_ITEMS  = 1750;
	localparam int QUIET_TAIL  = 200;
	localparam int PRESSURE_AT = 500;
	localparam int HOLD_CYCLES = 3000;
	localparam int DRAIN       = 300;
	localparam int LIMIT       = 3000000;
	localparam logic [PF:0] P_ZERO = '0;
	localparam logic [PF:0] P_LSB  = (PF+1)'(1);
	localparam logic [PF:0] P_ONE  = P_LSB << PF;
	localparam logic [PF:0] P_HALF = P_LSB << (PF - 1);
	localparam logic [PF:0] P_MAX  = '1;

	typedef struct packed {
		action_t       act;
		logic [1:0]    row;
		logic [1:0]    col;
		logic [CB-1:0] x;
		logic [CB-1:0] y;
		logic [CB-1:0] z;
		logic [PF:0]   u;
		logic [PF:0]   v;
	} req_beat_t;

	logic clk = 1'b0;
	logic arst_n;
	int   cycles = 0;
	int   fail_count;
	int   results_due;
	int   idle_pct;
	bit   tail_quiet;
	bit   hold_rsp;
	int   n_loads;
	int   n_evals;
	int   n_sat;

	bbp_in_if  req_ch ();
	bbp_out_if rsp_ch ();

	bicubic_bezier_patch_eval uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	bicubic_bezier_patch_eval_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.err_count (fail_count),
		.pending   (results_due)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Coordinate mix: extremes, values near zero for rounding ties, full range
	function automatic logic [CB-1:0] pick_coord();
		case ($urandom_range(0, 9))
			0: return {1'b1, {(CB-1){1'b0}}};
			1: return {1'b0, {(CB-1){1'b1}}};
			2, 3: return CB'($signed($urandom_range(0, 128)) - 64);
			default: return CB'($urandom);
		endcase
	endfunction

	// Parameter mix: ends, midpoint, values past one, anywhere in range
	function automatic logic [PF:0] pick_param();
		case ($urandom_range(0, 9))
			0: return P_ZERO;
			1: return P_ONE;
			2: return P_HALF;
			3: return (PF+1)'($urandom);
			default: return (PF+1)'($urandom_range(0, 1 << PF));
		endcase
	endfunction

	function automatic req_beat_t load_beat(input logic [1:0] row, input logic [1:0] col,
			input logic [CB-1:0] x, input logic [CB-1:0] y, input logic [CB-1:0] z);
		req_beat_t b;
		b.act = ACT_LOAD;
		b.row = row;
		b.col = col;
		b.x = x;
		b.y = y;
		b.z = z;
		b.u = (PF+1)'($urandom);
		b.v = (PF+1)'($urandom);
		return b;
	endfunction

	function automatic req_beat_t eval_beat(input logic [PF:0] u, input logic [PF:0] v);
		req_beat_t b;
		b.act = ACT_EVAL;
		b.row = 2'($urandom);
		b.col = 2'($urandom);
		b.x = CB'($urandom);
		b.y = CB'($urandom);
		b.z = CB'($urandom);
		b.u = u;
		b.v = v;
		return b;
	endfunction

	// Present one beat, maybe after an idle burst, and hold it until taken
	task automatic offer(input req_beat_t b);
		int gap;
		if (!tail_quiet && $urandom_range(0, 99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			gap = $urandom_range(1, 14);
			repeat (gap) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.action    <= b.act;
		req_ch.point_row <= b.row;
		req_ch.point_col <= b.col;
		req_ch.coord_x   <= b.x;
		req_ch.coord_y   <= b.y;
		req_ch.coord_z   <= b.z;
		req_ch.param_u   <= b.u;
		req_ch.param_v   <= b.v;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		if (b.act == ACT_EVAL) begin
			n_evals++;
			if (b.u > P_ONE || b.v > P_ONE)
				n_sat++;
		end else begin
			n_loads++;
		end
	endtask

	// Result side: random hold-off bursts, one long hold on request
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		rsp_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_rsp && !hold_done) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else if (!tail_quiet && $urandom_range(0, 99) < idle_pct) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		req_beat_t b;
		int i;
		idle_pct = 20;
		tail_quiet = 1'b0;
		hold_rsp = 1'b0;
		n_loads = 0;
		n_evals = 0;
		n_sat = 0;
		arst_n <= 1'b0;
		req_ch.valid     <= 1'b0;
		req_ch.action    <= ACT_LOAD;
		req_ch.point_row <= '0;
		req_ch.point_col <= '0;
		req_ch.coord_x   <= '0;
		req_ch.coord_y   <= '0;
		req_ch.coord_z   <= '0;
		req_ch.param_u   <= '0;
		req_ch.param_v   <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty grid, rounding ties both ways, corners, saturation
		offer(eval_beat(P_HALF, P_HALF));
		offer(load_beat(2'd0, 2'd0, 16'sd32, -16'sd32, 16'sd96));
		offer(eval_beat(P_HALF, P_HALF));
		offer(eval_beat(P_ZERO, P_ZERO));
		offer(load_beat(2'd0, 2'd0, 16'sh7FFF, 16'sh8000, -16'sd1));
		offer(load_beat(2'd3, 2'd3, 16'sh8000, 16'sh7FFF, 16'sd1));
		offer(load_beat(2'd0, 2'd3, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
		offer(load_beat(2'd3, 2'd0, 16'sh8000, 16'sh8000, 16'sh8000));
		offer(eval_beat(P_ZERO, P_ZERO));
		offer(eval_beat(P_ONE, P_ONE));
		offer(eval_beat(P_MAX, P_ONE + P_LSB));
		offer(eval_beat(P_ZERO, P_MAX));
		offer(eval_beat(P_ONE, P_ZERO));
		offer(eval_beat(P_LSB, P_LSB));
		offer(eval_beat(P_ONE - P_LSB, P_ONE - P_LSB));
		offer(eval_beat(P_HALF, P_ONE - P_LSB));
		offer(load_beat(2'd1, 2'd2, 16'sh7FFF, 16'sh8000, 16'sh5555));
		offer(load_beat(2'd2, 2'd1, 16'sh8000, 16'sh7FFF, 16'shAAAA));
		offer(eval_beat(P_HALF, P_HALF));
		offer(eval_beat(P_MAX, P_ZERO));

		// Random: mixed loads and evaluations under changing idle density
		for (i = 0; i < RAND_ITEMS; i++) begin
			if (i % 150 == 0)
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 15;
					default: idle_pct = 40;
				endcase
			if (i == PRESSURE_AT)
				hold_rsp = 1'b1;
			if (i == RAND_ITEMS - QUIET_TAIL)
				tail_quiet = 1'b1;
			if ($urandom_range(0, 99) < 45)
				b = eval_beat(pick_param(), pick_param());
			else
				b = load_beat(2'($urandom), 2'($urandom), pick_coord(), pick_coord(),
					pick_coord());
			offer(b);
		end
		req_ch.valid <= 1'b0;

		// Drain outstanding points, then watch for strays
		while (results_due != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("covered %0d control point loads and %0d evaluations, %0d of them",
			n_loads, n_evals, n_sat);
		$display("with a parameter past one, plus a %0d cycle result hold-off", HOLD_CYCLES);
		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
